### design/clt_pkg.sv
// Shared constants, types and helpers of the configuration line tokenizer.
`default_nettype none

package clt_pkg;

   localparam int TOKEN_BUFFER = 128;
   localparam int LEN_W        = $clog2(TOKEN_BUFFER);
   localparam int TOKEN_LIMIT  = TOKEN_BUFFER - 1;
   localparam int BYTE_W       = 8;
   localparam int LINE_W       = 16;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_WORD    = 3'd1;
   localparam logic [2:0] MODE_QUOTE   = 3'd2;
   localparam logic [2:0] MODE_QSKIP   = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;

   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;
   localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;
   localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] char_byte;
   } req_type;

   typedef struct packed {
      logic              is_end_marker;
      logic [BYTE_W-1:0] token_byte;
      logic              first_of_line;
      logic [LINE_W-1:0] line_number;
   } rsp_type;

   function automatic logic is_white(input logic [BYTE_W-1:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0D) ||
             (c == 8'h0C) || (c == 8'hAD) || (c == 8'h00);
   endfunction

endpackage

`default_nettype wire

### design/clt_ifs.sv
// Channel interfaces: request, response and control-register write.
`default_nettype none

interface clt_req_if;
   import clt_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] char_byte;
   modport source (output valid, kind, char_byte, input ready);
   modport sink (input valid, kind, char_byte, output ready);
endinterface

interface clt_rsp_if;
   import clt_pkg::*;
   logic              valid;
   logic              ready;
   logic              is_end_marker;
   logic [BYTE_W-1:0] token_byte;
   logic              first_of_line;
   logic [LINE_W-1:0] line_number;
   modport source (output valid, is_end_marker, token_byte, first_of_line, line_number,
                   input ready);
   modport sink (input valid, is_end_marker, token_byte, first_of_line, line_number,
                 output ready);
endinterface

interface clt_csr_if;
   logic valid;
   logic ready;
   logic fold_first_word;
   modport source (output valid, fold_first_word, input ready);
   modport sink (input valid, fold_first_word, output ready);
endinterface

`default_nettype wire

### design/config_line_tokenizer.sv
// Top level of the configuration line tokenizer.
// Splits a text byte stream into words. Each request on req_if carries one
// text byte (kind 0) or an end-of-input mark (kind 1). The first TOKEN_LIMIT
// bytes of each token leave on rsp_if as they arrive, then one end marker; the
// first token of a line is flagged and every result carries its line number.
// csr_if writes fold_first_word (reset 1); it is always ready, and the user
// must write it only while the block is idle; the block does not enforce this.
// A request is held in the input register, then the scan logic writes its
// result into the result register; a stalled sink can hold it in between.
// Throughput: one request per cycle unless the sink stalls; the scan state
// updates once per step. A request that gives no result still passes through.
// Reset returns the scanner to between tokens at line 1 and empties both
// registers. When the sink stalls, the result register holds, the input
// register fills, and then req_if.ready drops until the sink takes a result.
// End of input closes an open token and clears the scan state for a new file.
`default_nettype none

module config_line_tokenizer (
   input  wire logic clock,
   input  wire logic reset,
   clt_req_if.sink   req_if,
   clt_rsp_if.source rsp_if,
   clt_csr_if.sink   csr_if
);
   import clt_pkg::*;

   logic    fold_ff, fold_in;
   logic    item_valid, out_free, step, res_valid;
   req_type item;
   rsp_type res;

   assign csr_if.ready = 1'b1;
   assign fold_in      = (csr_if.valid && csr_if.ready) ? csr_if.fold_first_word : fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b1;
      end else begin
         fold_ff <= fold_in;
      end
   end

   assign step = item_valid && out_free;

   clt_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (out_free),
      .item_valid (item_valid),
      .item       (item)
   );

   clt_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .item            (item),
      .fold_first_word (fold_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   clt_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (step && res_valid),
      .res    (res),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.line_number != '0)
      else $error("result with line number zero");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_end_marker) |-> rsp_if.token_byte == '0)
      else $error("end marker carries a byte");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without a stalled result");

endmodule

`default_nettype wire

### design/clt_in_stage.sv
// Input register: takes one request per cycle while empty or being drained.
`default_nettype none

module clt_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   clt_req_if.sink              req_if,
   input  wire logic            take,
   output logic                 item_valid,
   output clt_pkg::req_type     item
);
   import clt_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    load;

   assign req_if.ready = !valid_ff || take;
   assign load         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in          = 1'b1;
         item_in.kind      = req_if.kind;
         item_in.char_byte = req_if.char_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### design/clt_scan.sv
// Scanner state and next-state logic: one byte per step, at most one result.
`default_nettype none

module clt_scan (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire clt_pkg::req_type item,
   input  wire logic            fold_first_word,
   output logic                 res_valid,
   output clt_pkg::rsp_type     res
);
   import clt_pkg::*;

   logic [2:0]        mode_ff, mode_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic              fresh_ff, fresh_in;
   logic              first_ff, first_in;

   logic [LEN_W-1:0]  len_plus;
   logic [BYTE_W-1:0] c;
   logic              is_end, res_first;
   logic [LINE_W-1:0] line_bump;

   assign c         = item.char_byte;
   assign len_plus  = len_ff + LEN_W'(1);
   assign line_bump = (line_ff != LINE_MAX) ? line_ff + LINE_W'(1) : line_ff;

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      fresh_in  = fresh_ff;
      first_in  = first_ff;
      res_valid = 1'b0;
      is_end    = 1'b0;
      res_first = first_ff;
      if (item.kind == KIND_EOF) begin
         // close any open token, then back to reset state
         res_valid = (mode_ff == MODE_WORD) || (mode_ff == MODE_QUOTE) ||
                     (mode_ff == MODE_QSKIP);
         is_end    = 1'b1;
         mode_in   = MODE_IDLE;
         len_in    = '0;
         line_in   = LINE_FIRST;
         fresh_in  = 1'b1;
         first_in  = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_WORD: begin
               if (is_white(c)) begin
                  mode_in   = MODE_IDLE;
                  res_valid = 1'b1;
                  is_end    = 1'b1;
               end else if (c == CH_NEWLINE) begin
                  mode_in   = MODE_IDLE;
                  res_valid = 1'b1;
                  is_end    = 1'b1;
                  line_in   = line_bump;
                  fresh_in  = 1'b1;
               end else if (c == CH_SEMI || c == CH_SLASH) begin
                  mode_in   = MODE_COMMENT;
                  res_valid = 1'b1;
                  is_end    = 1'b1;
               end else if (len_ff < LEN_W'(TOKEN_LIMIT)) begin
                  len_in    = len_plus;
                  res_valid = 1'b1;
               end
            end
            MODE_QUOTE: begin
               if (c == CH_QUOTE) begin
                  mode_in   = MODE_IDLE;
                  res_valid = 1'b1;
                  is_end    = 1'b1;
               end else begin
                  len_in    = len_plus;
                  res_valid = 1'b1;
                  if (len_plus >= LEN_W'(TOKEN_LIMIT)) begin
                     mode_in = MODE_QSKIP;
                  end
               end
            end
            MODE_QSKIP: begin
               if (c == CH_QUOTE) begin
                  mode_in   = MODE_IDLE;
                  res_valid = 1'b1;
                  is_end    = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  mode_in  = MODE_IDLE;
                  line_in  = line_bump;
                  fresh_in = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               if (c == CH_NEWLINE) begin
                  line_in  = line_bump;
                  fresh_in = 1'b1;
               end else if (is_white(c)) begin
                  mode_in = MODE_IDLE;
               end else if (c == CH_SEMI || c == CH_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  first_in  = fresh_ff;
                  res_first = fresh_ff;
                  fresh_in  = 1'b0;
                  len_in    = '0;
                  if (c == CH_QUOTE) begin
                     mode_in = MODE_QUOTE;
                  end else begin
                     mode_in   = MODE_WORD;
                     len_in    = LEN_W'(1);
                     res_valid = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      res.is_end_marker = is_end;
      res.first_of_line = res_first;
      res.line_number   = line_ff;
      res.token_byte    = c;
      if (is_end) begin
         res.token_byte = '0;
      end else if (res_first && fold_first_word && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
         res.token_byte = c - CASE_DELTA;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         len_ff   <= '0;
         line_ff  <= LINE_FIRST;
         fresh_ff <= 1'b1;
         first_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         fresh_ff <= fresh_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

### design/clt_out_stage.sv
// Result register: holds one token byte or end marker until the sink takes it.
`default_nettype none

module clt_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire clt_pkg::rsp_type res,
   output logic                  free,
   clt_rsp_if.source             rsp_if
);
   import clt_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = load;
         if (load) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.is_end_marker = data_ff.is_end_marker;
   assign rsp_if.token_byte    = data_ff.token_byte;
   assign rsp_if.first_of_line = data_ff.first_of_line;
   assign rsp_if.line_number   = data_ff.line_number;

endmodule

`default_nettype wire

### bench/tb_config_line_tokenizer.sv
// Self-checking bench for config_line_tokenizer: text streams in, predicted token results checked.
module tb_config_line_tokenizer;
   import clt_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 390;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_AT_A      = 150;
   localparam int HOLD_AT_B      = 700;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_PRINTED    = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   clt_req_if req_if ();
   clt_rsp_if rsp_if ();
   clt_csr_if csr_if ();

   config_line_tokenizer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #6 clock = ~clock;

   // shadow copy of the scanner
   logic [2:0]        scan_mode;
   logic [LEN_W-1:0]  scan_len;
   logic [LINE_W-1:0] scan_line;
   logic              scan_fresh;
   logic              scan_first;
   logic              fold_upper = 1'b1;

   req_type pending_bytes[$];
   rsp_type expected_tokens[$];

   int errors        = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int csr_writes    = 0;
   int queued        = 0;
   int gap_left      = 0;
   int stall_left    = 0;
   int hold_left     = 0;
   int idle_cycles   = 0;
   bit calm          = 1'b0;

   function automatic bit blank_char(input logic [BYTE_W-1:0] c);
      case (c)
         8'h20, 8'h09, 8'h0B, 8'h0D, 8'h0C, 8'hAD, 8'h00: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   task automatic clear_scan();
      scan_mode  = MODE_IDLE;
      scan_len   = '0;
      scan_line  = LINE_FIRST;
      scan_fresh = 1'b1;
      scan_first = 1'b0;
   endtask

   task automatic next_line();
      if (scan_line != LINE_MAX)
         scan_line++;
      scan_fresh = 1'b1;
   endtask

   task automatic expect_token(input logic marker, input logic [BYTE_W-1:0] b);
      rsp_type r;
      r.is_end_marker = marker;
      r.token_byte    = marker ? '0 : b;
      if (!marker && scan_first && fold_upper && b >= CH_LOWER_A && b <= CH_LOWER_Z)
         r.token_byte = b - CASE_DELTA;
      r.first_of_line = scan_first;
      r.line_number   = scan_line;
      expected_tokens.push_back(r);
   endtask

   task automatic scan_step(input req_type item);
      logic [BYTE_W-1:0] c;
      c = item.char_byte;
      if (item.kind == KIND_EOF) begin
         if (scan_mode == MODE_WORD || scan_mode == MODE_QUOTE || scan_mode == MODE_QSKIP)
            expect_token(1'b1, '0);
         clear_scan();
      end else begin
         case (scan_mode)
            MODE_WORD: begin
               if (blank_char(c)) begin
                  scan_mode = MODE_IDLE;
                  expect_token(1'b1, '0);
               end else if (c == CH_NEWLINE) begin
                  expect_token(1'b1, '0);
                  scan_mode = MODE_IDLE;
                  next_line();
               end else if (c == CH_SEMI || c == CH_SLASH) begin
                  scan_mode = MODE_COMMENT;
                  expect_token(1'b1, '0);
               end else if (scan_len < TOKEN_LIMIT) begin
                  scan_len++;
                  expect_token(1'b0, c);
               end
            end
            MODE_QUOTE: begin
               if (c == CH_QUOTE) begin
                  scan_mode = MODE_IDLE;
                  expect_token(1'b1, '0);
               end else begin
                  scan_len++;
                  if (scan_len >= TOKEN_LIMIT)
                     scan_mode = MODE_QSKIP;
                  expect_token(1'b0, c);
               end
            end
            MODE_QSKIP: begin
               if (c == CH_QUOTE) begin
                  scan_mode = MODE_IDLE;
                  expect_token(1'b1, '0);
               end
            end
            MODE_COMMENT: begin
               if (c == CH_NEWLINE) begin
                  scan_mode = MODE_IDLE;
                  next_line();
               end
            end
            default: begin
               scan_mode = MODE_IDLE;
               if (c == CH_NEWLINE) begin
                  next_line();
               end else if (c == CH_SEMI || c == CH_SLASH) begin
                  scan_mode = MODE_COMMENT;
               end else if (!blank_char(c)) begin
                  scan_first = scan_fresh;
                  scan_fresh = 1'b0;
                  if (c == CH_QUOTE) begin
                     scan_mode = MODE_QUOTE;
                     scan_len  = '0;
                  end else begin
                     scan_mode = MODE_WORD;
                     scan_len  = 1;
                     expect_token(1'b0, c);
                  end
               end
            end
         endcase
      end
   endtask

   task automatic note_mismatch(input string msg);
      if (errors < MAX_PRINTED)
         $display("MISMATCH: %s", msg);
      errors++;
   endtask

   // ---------------- stimulus generation ----------------

   task automatic queue_byte(input logic [BYTE_W-1:0] c);
      req_type r;
      r.kind      = KIND_BYTE;
      r.char_byte = c;
      pending_bytes.push_back(r);
      queued++;
   endtask

   task automatic queue_eof();
      req_type r;
      r.kind      = KIND_EOF;
      r.char_byte = 8'($urandom_range(0, 255));
      pending_bytes.push_back(r);
      queued++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_blank();
      case ($urandom_range(0, 6))
         0: return 8'h09;
         1: return 8'h0B;
         2: return 8'h0D;
         3: return 8'h0C;
         4: return 8'hAD;
         5: return 8'h00;
         default: return 8'h20;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] word_char(input bit lead);
      logic [BYTE_W-1:0] c;
      int pick;
      do begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            c = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
         else if (pick < 8)
            c = 8'($urandom_range(8'h21, 8'h7E));
         else
            c = 8'($urandom_range(0, 255));
      end while (blank_char(c) || c == CH_NEWLINE || c == CH_SEMI || c == CH_SLASH ||
                 (lead && c == CH_QUOTE));
      return c;
   endfunction

   task automatic queue_word();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 140) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
         queue_byte(word_char(i == 0));
   endtask

   task automatic queue_quoted();
      int n;
      logic [BYTE_W-1:0] c;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(124, 134) : $urandom_range(0, 8);
      queue_byte(CH_QUOTE);
      for (int i = 0; i < n; i++) begin
         c = ($urandom_range(0, 9) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255));
         if (c == CH_QUOTE)
            c = 8'h27;
         queue_byte(c);
      end
      queue_byte(CH_QUOTE);
   endtask

   task automatic queue_line();
      int pick;
      int ntok;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 7) begin
         queue_eof();
      end else begin
         if ($urandom_range(0, 3) == 0)
            queue_byte(pick_blank());
         ntok = $urandom_range(0, 4);
         for (int t = 0; t < ntok; t++) begin
            if (t != 0)
               repeat ($urandom_range(1, 2)) queue_byte(pick_blank());
            if ($urandom_range(0, 9) < 7)
               queue_word();
            else
               queue_quoted();
         end
         if (pick < 12) begin
            queue_eof();   // file cut off mid-line
         end else begin
            if ($urandom_range(0, 6) == 0) begin
               queue_byte($urandom_range(0, 1) ? CH_SEMI : CH_SLASH);
               repeat ($urandom_range(0, 10)) queue_byte(word_char(1'b0));
            end
            queue_byte(CH_NEWLINE);
         end
      end
   endtask

   task automatic queue_random(input int count);
      int start;
      start = queued;
      while (queued - start < count)
         queue_line();
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_if.valid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fold(input logic v);
      @(posedge clock);
      csr_if.valid           <= 1'b1;
      csr_if.fold_first_word <= v;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      fold_upper = v;
      csr_writes++;
   endtask

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      req_type next_item;
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.kind      <= KIND_BYTE;
         req_if.char_byte <= '0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            next_item.kind      = req_if.kind;
            next_item.char_byte = req_if.char_byte;
            scan_step(next_item);
            requests_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               next_item = pending_bytes.pop_front();
               req_if.kind      <= next_item.kind;
               req_if.char_byte <= next_item.char_byte;
               req_if.valid     <= 1'b1;
               if (!calm && $urandom_range(0, 9) < 3)
                  gap_left = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- result monitor ----------------

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_tokens.size() == 0) begin
               note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_if.is_end_marker !== want.is_end_marker)
                  note_mismatch($sformatf("result %0d: is_end_marker %b, expected %b",
                                          results_seen, rsp_if.is_end_marker,
                                          want.is_end_marker));
               if (rsp_if.token_byte !== want.token_byte)
                  note_mismatch($sformatf("result %0d: token_byte %h, expected %h",
                                          results_seen, rsp_if.token_byte, want.token_byte));
               if (rsp_if.first_of_line !== want.first_of_line)
                  note_mismatch($sformatf("result %0d: first_of_line %b, expected %b",
                                          results_seen, rsp_if.first_of_line,
                                          want.first_of_line));
               if (rsp_if.line_number !== want.line_number)
                  note_mismatch($sformatf("result %0d: line_number %0d, expected %0d",
                                          results_seen, rsp_if.line_number, want.line_number));
            end
            // long hold-off so the block backs up into its input
            if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (calm) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
               stall_left = pick_gap();
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_tokens.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      logic [BYTE_W-1:0] directed_text[$];
      req_if.valid           = 1'b0;
      req_if.kind            = KIND_BYTE;
      req_if.char_byte       = '0;
      rsp_if.ready           = 1'b0;
      csr_if.valid           = 1'b0;
      csr_if.fold_first_word = 1'b1;
      clear_scan();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // first word folded, empty quote, quote inside a word, comment ends a word,
      // quoted token spanning a newline, 0xFF word ended by NUL, every blank but space
      directed_text = '{8'h7A, 8'h41, 8'h09, CH_QUOTE, CH_QUOTE, 8'h78, CH_QUOTE, 8'h79,
                        CH_SEMI, 8'h63, CH_NEWLINE, CH_QUOTE, 8'h71, CH_NEWLINE, 8'h72,
                        CH_QUOTE, CH_SLASH, CH_NEWLINE, 8'hFF, 8'h00, 8'hAD, 8'h0B, 8'h0D,
                        8'h0C, 8'h6D};
      foreach (directed_text[i])
         queue_byte(directed_text[i]);
      queue_eof();   // closes the open word
      queue_eof();   // nothing open
      wait_idle();

      write_fold(1'b0);
      queue_random(PHASE_ITEMS);
      wait_idle();

      calm = 1'b1;
      write_fold(1'b1);
      queue_random(PHASE_ITEMS);
      wait_idle();

      calm = 1'b0;
      write_fold(1'b0);
      queue_random(PHASE_ITEMS);
      wait_idle();

      write_fold(1'b1);
      queue_random(PHASE_ITEMS);
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Ran %0d requests giving %0d token results over %0d fold writes, both settings,",
               requests_sent, results_seen, csr_writes);
      $display("with overlong words and quotes, comments, cut-off files and long output stalls.");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

### sim.f
design/clt_pkg.sv
design/clt_ifs.sv
design/clt_in_stage.sv
design/clt_scan.sv
design/clt_out_stage.sv
design/config_line_tokenizer.sv
bench/tb_config_line_tokenizer.sv
